// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is active.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, off while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that also holds through reset.
`define ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/nee_pkg.sv -----
`timescale 1ns / 1ps

package nee_pkg;

    localparam int VALUE_W = 8;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 4;
    localparam int IDX_W   = 2;

    localparam logic [IDX_W-1:0] REG_EFFICIENT_LOW  = 2'd0;
    localparam logic [IDX_W-1:0] REG_EFFICIENT_HIGH = 2'd1;
    localparam logic [IDX_W-1:0] REG_ESCAPE_NIBBLE  = 2'd2;

    localparam logic [CFG_W-1:0] RST_EFFICIENT_LOW  = 4'd0;
    localparam logic [CFG_W-1:0] RST_EFFICIENT_HIGH = 4'd14;
    localparam logic [CFG_W-1:0] RST_ESCAPE_NIBBLE  = 4'd15;

    typedef struct packed {
        logic [CFG_W-1:0] efficient_low;
        logic [CFG_W-1:0] efficient_high;
        logic [CFG_W-1:0] escape_nibble;
    } nee_cfg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              last_of_run;
        logic              stream_end;
    } nee_entry_t;

    typedef struct packed {
        logic [1:0] count;
        nee_entry_t ent0;
        nee_entry_t ent1;
    } nee_push_t;

endpackage

// ----- rtl/nee_encode.sv -----
`timescale 1ns / 1ps

module nee_encode
    import nee_pkg::*;
#(
    parameter int NIBBLE_BITS = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  nee_cfg_t                  cfg,
    input  logic signed [VALUE_W-1:0] value,
    input  logic                      end_of_stream,
    input  logic                      consume,
    output nee_push_t                 push
);

    typedef logic [NIBBLE_BITS-1:0] nib_t;

    function automatic logic [BYTE_W-1:0] pack(input nib_t first, input nib_t second);
        logic [15:0] w;
        w = 16'({first, second});
        return w[BYTE_W-1:0];
    endfunction

    logic                      pend_valid_reg, pend_valid_next;
    nib_t                      pend_nib_reg, pend_nib_next;
    logic signed [VALUE_W:0]   sv_ext;
    logic signed [VALUE_W:0]   low_ext, high_ext;
    logic                      direct;
    logic [VALUE_W-1:0]        hi_full;
    nib_t                      nib_d, nib_hi, nib_lo, nib_esc;
    logic [1:0]                k;
    logic [BYTE_W-1:0]         byte0, byte1;

    assign sv_ext   = (VALUE_W+1)'(value);
    assign low_ext  = $signed({{(VALUE_W+1-CFG_W){1'b0}}, cfg.efficient_low});
    assign high_ext = $signed({{(VALUE_W+1-CFG_W){1'b0}}, cfg.efficient_high});
    assign direct   = (sv_ext >= low_ext) && (sv_ext <= high_ext);
    assign hi_full  = VALUE_W'(value) >> NIBBLE_BITS;
    assign nib_hi   = hi_full[NIBBLE_BITS-1:0];
    assign nib_lo   = value[NIBBLE_BITS-1:0];
    assign nib_d    = value[NIBBLE_BITS-1:0];
    assign nib_esc  = NIBBLE_BITS'(cfg.escape_nibble);

    always_comb begin
        k               = 2'd0;
        byte0           = '0;
        byte1           = '0;
        pend_valid_next = 1'b0;
        pend_nib_next   = '0;
        case ({pend_valid_reg, direct})
            2'b01: begin
                if (end_of_stream) begin
                    k     = 2'd1;
                    byte0 = pack(nib_d, nib_esc);
                end else begin
                    pend_valid_next = 1'b1;
                    pend_nib_next   = nib_d;
                end
            end
            2'b00: begin
                byte0 = pack(nib_esc, nib_hi);
                if (end_of_stream) begin
                    k     = 2'd2;
                    byte1 = pack(nib_lo, nib_esc);
                end else begin
                    k               = 2'd1;
                    pend_valid_next = 1'b1;
                    pend_nib_next   = nib_lo;
                end
            end
            2'b11: begin
                k     = 2'd1;
                byte0 = pack(pend_nib_reg, nib_d);
            end
            default: begin
                k     = 2'd2;
                byte0 = pack(pend_nib_reg, nib_esc);
                byte1 = pack(nib_hi, nib_lo);
            end
        endcase
    end

    always_comb begin
        push.count            = k;
        push.ent0.packed_byte = byte0;
        push.ent0.last_of_run = (k == 2'd1);
        push.ent0.stream_end  = end_of_stream && (k == 2'd1);
        push.ent1.packed_byte = byte1;
        push.ent1.last_of_run = 1'b1;
        push.ent1.stream_end  = end_of_stream;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            pend_nib_reg   <= '0;
        end else if (consume) begin
            pend_valid_reg <= pend_valid_next;
            pend_nib_reg   <= pend_nib_next;
        end
    end

endmodule

// ----- rtl/nee_outq.sv -----
`timescale 1ns / 1ps

module nee_outq
    import nee_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push_valid,
    input  nee_push_t         push,
    output logic              push_ready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tlast,
    output logic              m_tuser
);

    logic [1:0] cnt_reg, cnt_next;
    nee_entry_t q0_reg, q0_next;
    nee_entry_t q1_reg, q1_next;
    logic       pop;
    logic [1:0] rem;
    logic [2:0] total;
    logic       push_fire;

    assign m_tvalid   = (cnt_reg != 2'd0);
    assign pop        = m_tvalid && m_tready;
    assign rem        = cnt_reg - {1'b0, pop};
    assign total      = {1'b0, rem} + {1'b0, push.count};
    assign push_ready = (total <= 3'd2);
    assign push_fire  = push_valid && push_ready;

    assign m_tdata = q0_reg.packed_byte;
    assign m_tlast = q0_reg.last_of_run;
    assign m_tuser = q0_reg.stream_end;

    always_comb begin
        q0_next  = pop ? q1_reg : q0_reg;
        q1_next  = q1_reg;
        cnt_next = rem;
        if (push_fire) begin
            cnt_next = total[1:0];
            case (rem)
                2'd0: begin
                    q0_next = push.ent0;
                    q1_next = push.ent1;
                end
                2'd1: begin
                    q1_next = push.ent0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

// ----- rtl/nibble_escape_encoder.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Payload
// s_        in         tdata[7:0] value (signed), tlast end_of_stream
// m_        out        tdata[7:0] packed_byte, tlast last_of_run, tuser stream_end
// cfg_      in         cfg_index register, cfg_data[3:0] value
//
// One item sits in the input register and is encoded into the two-entry output queue
// in the cycle it is taken; a new item can enter every cycle while the queue has room.
// An escaped value yields up to two bytes; the output port moves one byte per cycle while
// m_tready is high, so a new item waits until the queue has room for its bytes.
// Reset clears the pending nibble, the queue and restores register defaults.
// A stall on m_tready holds the queue; s_tready drops once the queue has no room.

module nibble_escape_encoder
    import nee_pkg::*;
#(
    parameter int NIBBLE_BITS = 4
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic signed [VALUE_W-1:0] s_tdata,   // [7:0] value
    input  logic                      s_tlast,   // end_of_stream
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [BYTE_W-1:0]         m_tdata,   // [7:0] packed_byte
    output logic                      m_tlast,   // last_of_run
    output logic                      m_tuser,   // [0] stream_end
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [IDX_W-1:0]          cfg_index,
    input  logic [CFG_W-1:0]          cfg_data
);

    nee_cfg_t                  cfg_reg;
    logic                      a_valid_reg;
    logic signed [VALUE_W-1:0] a_value_reg;
    logic                      a_eos_reg;
    logic                      push_ready;
    logic                      consume;
    nee_push_t                 push;

    assign cfg_ready = 1'b1;
    assign consume   = a_valid_reg && push_ready;
    assign s_tready  = !a_valid_reg || consume;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.efficient_low  <= RST_EFFICIENT_LOW;
            cfg_reg.efficient_high <= RST_EFFICIENT_HIGH;
            cfg_reg.escape_nibble  <= RST_ESCAPE_NIBBLE;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_EFFICIENT_LOW:  cfg_reg.efficient_low  <= cfg_data;
                REG_EFFICIENT_HIGH: cfg_reg.efficient_high <= cfg_data;
                REG_ESCAPE_NIBBLE:  cfg_reg.escape_nibble  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            a_valid_reg <= 1'b1;
        end else if (consume) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            a_value_reg <= s_tdata;
            a_eos_reg   <= s_tlast;
        end
    end

    nee_encode #(
        .NIBBLE_BITS(NIBBLE_BITS)
    ) u_encode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .value         (a_value_reg),
        .end_of_stream (a_eos_reg),
        .consume       (consume),
        .push          (push)
    );

    nee_outq u_outq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (a_valid_reg),
        .push       (push),
        .push_ready (push_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

// ----- rtl/nee_checker.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

module nee_checker
    import nee_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [BYTE_W-1:0] m_tdata,
    input logic              m_tlast,
    input logic              m_tuser
);

    logic [BYTE_W+1:0] m_payload;

    assign m_payload = {m_tdata, m_tlast, m_tuser};

    // hold a stalled result transaction
    `ASSERT_NEXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_payload))
    // stream end closes the run of its item
    `ASSERT_IMPLY(a_end_is_last, aclk, aresetn, m_tvalid && m_tuser, m_tlast)
    // drop all queued results on reset
    `ASSERT_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

endmodule

bind nibble_escape_encoder nee_checker u_nee_checker (.*);
